### rtl/core/whole_word_pattern_search_macros.svh
// Assertion macros shared by the checker.
`ifndef WHOLE_WORD_PATTERN_SEARCH_MACROS_SVH
`define WHOLE_WORD_PATTERN_SEARCH_MACROS_SVH

// Checked on every clock edge outside reset.
`define WWPS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("whole word search check failed");

// Checked on every clock edge, reset included.
`define WWPS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk_i) prop) \
    else $error("whole word search check failed");

`endif

### rtl/core/wwps_pkg.sv
package wwps_pkg;

  localparam int PatternBytes = 8;
  localparam int MaxText      = 65536;
  localparam int HistDepth    = PatternBytes + 1;
  localparam int WinDepth     = PatternBytes + 2;
  localparam int IdxW         = $clog2(WinDepth);
  localparam int LenW         = 4;
  localparam int PosW         = 16;
  localparam int CountW       = $clog2(MaxText + 2);
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 64;
  localparam int QueueDepth   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    RegPattern  = 3'd0,
    RegLength   = 3'd1,
    RegLetter0  = 3'd2,
    RegLetter1  = 3'd3,
    RegLetter2  = 3'd4,
    RegLetter3  = 3'd5,
    RegOptions  = 3'd6,
    RegStart    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [8*PatternBytes-1:0] pattern_bytes;
    logic [LenW-1:0]           pattern_length;
    logic [255:0]              letters;
    logic                      case_exact;
    logic                      any_match;
    logic                      backward;
    logic [PosW-1:0]           start_position;
  } cfg_t;

  typedef struct packed {
    logic            hit_a;
    logic [PosW-1:0] pos_a;
    logic            hit_b;
    logic [PosW-1:0] pos_b;
    logic            last;
  } cand_t;

endpackage

### rtl/core/wwps_cfg.sv
module wwps_cfg
  import wwps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        RegPattern: cfg_d.pattern_bytes  = cfg_data_i[8*PatternBytes-1:0];
        RegLength:  cfg_d.pattern_length = cfg_data_i[LenW-1:0];
        RegLetter0: cfg_d.letters[63:0]    = cfg_data_i;
        RegLetter1: cfg_d.letters[127:64]  = cfg_data_i;
        RegLetter2: cfg_d.letters[191:128] = cfg_data_i;
        RegLetter3: cfg_d.letters[255:192] = cfg_data_i;
        RegOptions: begin
          cfg_d.case_exact = cfg_data_i[0];
          cfg_d.any_match  = cfg_data_i[1];
          cfg_d.backward   = cfg_data_i[2];
        end
        RegStart:   cfg_d.start_position = cfg_data_i[PosW-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{pattern_bytes: '0, pattern_length: LenW'(1), letters: '0,
                 case_exact: 1'b1, any_match: 1'b0, backward: 1'b0,
                 start_position: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### rtl/core/wwps_front.sv
module wwps_front
  import wwps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  input  logic       last_i,
  input  logic       full_i,
  output logic       push_o,
  output cand_t      push_data_o
);

  logic [7:0]        hist_q [HistDepth];
  logic [7:0]        hist_d [HistDepth];
  logic [CountW-1:0] count_q;
  logic [CountW-1:0] count_d;

  logic [7:0]        win [WinDepth];
  logic [LenW-1:0]   m_eff;
  logic [CountW-1:0] m_ext;
  logic              mis_a;
  logic              mis_b;
  logic              ok_a;
  logic              ok_b;
  logic [7:0]        before_a;
  logic [7:0]        before_b;

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic byte_eq(input logic [7:0] a, input logic [7:0] b,
                                   input logic exact);
    logic r;
    r = exact ? (a == b) : (fold(a) == fold(b));
    return r;
  endfunction

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    m_eff = cfg_i.pattern_length;
    if (m_eff == '0) begin
      m_eff = LenW'(1);
    end else if (m_eff > LenW'(PatternBytes)) begin
      m_eff = LenW'(PatternBytes);
    end
    m_ext = CountW'(m_eff);

    win[0] = text_byte_i;
    for (int k = 0; k < HistDepth; k++) begin
      win[k+1] = hist_q[k];
    end

    mis_a = 1'b0;
    mis_b = 1'b0;
    for (int j = 0; j < PatternBytes; j++) begin
      if (LenW'(j) < m_eff) begin
        if (!byte_eq(win[IdxW'(m_eff) - IdxW'(j)], cfg_i.pattern_bytes[8*j +: 8],
                     cfg_i.case_exact)) begin
          mis_a = 1'b1;
        end
        if (!byte_eq(win[IdxW'(m_eff) - IdxW'(j + 1)], cfg_i.pattern_bytes[8*j +: 8],
                     cfg_i.case_exact)) begin
          mis_b = 1'b1;
        end
      end
    end

    before_a = win[IdxW'(m_eff) + IdxW'(1)];
    before_b = win[IdxW'(m_eff)];

    ok_a = cfg_i.any_match ||
           (!((count_q > m_ext) && cfg_i.letters[before_a]) &&
            !cfg_i.letters[text_byte_i]);
    ok_b = cfg_i.any_match ||
           !(((count_q + CountW'(1)) > m_ext) && cfg_i.letters[before_b]);

    push_data_o.hit_a = (count_q <= CountW'(MaxText)) && (count_q >= m_ext) &&
                        !mis_a && ok_a;
    push_data_o.pos_a = PosW'(count_q - m_ext);
    push_data_o.hit_b = last_i && (count_q < CountW'(MaxText)) &&
                        ((count_q + CountW'(1)) >= m_ext) && !mis_b && ok_b;
    push_data_o.pos_b = PosW'(count_q + CountW'(1) - m_ext);
    push_data_o.last  = last_i;
  end

  always_comb begin
    hist_d  = hist_q;
    count_d = count_q;
    if (push_o) begin
      if (last_i) begin
        for (int k = 0; k < HistDepth; k++) begin
          hist_d[k] = '0;
        end
        count_d = '0;
      end else begin
        if (count_q < CountW'(MaxText)) begin
          hist_d[0] = text_byte_i;
          for (int k = 1; k < HistDepth; k++) begin
            hist_d[k] = hist_q[k-1];
          end
        end
        if (count_q < CountW'(MaxText + 1)) begin
          count_d = count_q + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HistDepth; k++) begin
        hist_q[k] <= '0;
      end
      count_q <= '0;
    end else begin
      hist_q  <= hist_d;
      count_q <= count_d;
    end
  end

endmodule

### rtl/core/wwps_queue.sv
module wwps_queue
  import wwps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  cand_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output cand_t data_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cand_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q;
  logic [PtrW-1:0] wr_d;
  logic [PtrW-1:0] rd_q;
  logic [PtrW-1:0] rd_d;
  logic [CntW-1:0] cnt_q;
  logic [CntW-1:0] cnt_d;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] r;
    r = (ptr == PtrW'(QueueDepth - 1)) ? '0 : ptr + PtrW'(1);
    return r;
  endfunction

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? next_ptr(wr_q) : wr_q;
    rd_d  = pop_i ? next_ptr(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/core/wwps_back.sv
module wwps_back
  import wwps_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            q_valid_i,
  input  cand_t           q_data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            found_o,
  output logic [PosW-1:0] position_o
);

  logic            seen_q;
  logic            seen_d;
  logic [PosW-1:0] off_q;
  logic [PosW-1:0] off_d;
  logic            out_valid_q;
  logic            out_valid_d;
  logic            found_q;
  logic            found_d;
  logic [PosW-1:0] position_q;
  logic [PosW-1:0] position_d;
  logic            seen_a;
  logic [PosW-1:0] off_a;
  logic            seen_b;
  logic [PosW-1:0] off_b;

  assign pop_o       = q_valid_i && (!q_data_i.last || !out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign position_o  = position_q;

  always_comb begin
    seen_a = seen_q;
    off_a  = off_q;
    if (q_data_i.hit_a &&
        (cfg_i.backward || (!seen_q && (q_data_i.pos_a >= cfg_i.start_position)))) begin
      seen_a = 1'b1;
      off_a  = q_data_i.pos_a;
    end
    seen_b = seen_a;
    off_b  = off_a;
    if (q_data_i.hit_b &&
        (cfg_i.backward || (!seen_a && (q_data_i.pos_b >= cfg_i.start_position)))) begin
      seen_b = 1'b1;
      off_b  = q_data_i.pos_b;
    end

    seen_d      = seen_q;
    off_d       = off_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    position_d  = position_q;
    if (pop_o) begin
      if (q_data_i.last) begin
        seen_d      = 1'b0;
        off_d       = '0;
        out_valid_d = 1'b1;
        found_d     = seen_b;
        position_d  = seen_b ? off_b : '0;
      end else begin
        seen_d = seen_b;
        off_d  = off_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      seen_q      <= seen_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q    <= found_d;
    position_q <= position_d;
  end

endmodule

### rtl/core/whole_word_pattern_search.sv
// Whole-word pattern search over a byte stream.
// Text arrives one byte per beat on the input channel (text_byte_i, last_i);
// last_i marks the final byte of a text. Exactly one result beat (found_o,
// position_o) follows each text, giving the first match at or after the
// start position in forward mode, or the last match in backward mode.
// Configuration registers are written through the cfg channel, which is
// always ready; they should only be changed between texts.
// Throughput is one text byte per cycle while the queue is not full; the
// window compare in the front stage is fully parallel and the back stage
// retires one entry per cycle unless a final entry awaits a stalled result.
// The result beat is registered: the queue takes the classified final byte,
// then the back stage pops it and loads the result register.
// A two-entry queue separates front and back, so while a result beat is
// stalled by the receiver, text bytes are still taken until the queue fills.
// Reset clears the history, counters and match state, and restores the
// registers to their reset values (pattern length one, case-sensitive,
// whole-word, forward). No clearing pass is needed after reset.
module whole_word_pattern_search
  import wwps_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          text_byte_i,
  input  logic                last_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                found_o,
  output logic [PosW-1:0]     position_o
);

  cfg_t  cfg;
  logic  push;
  cand_t push_data;
  logic  full;
  logic  pop;
  logic  q_valid;
  cand_t q_data;

  wwps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wwps_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .text_byte_i (text_byte_i),
    .last_i      (last_i),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  wwps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  wwps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .found_o     (found_o),
    .position_o  (position_o)
  );

endmodule

### rtl/core/wwps_checker.sv
`include "whole_word_pattern_search_macros.svh"

module wwps_checker
  import wwps_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            cfg_ready_o,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic            found_o,
  input logic [PosW-1:0] position_o
);

  // A stalled result beat keeps its payload.
  `WWPS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_o) && $stable(position_o))

  // Without a match the position reads zero.
  `WWPS_ASSERT(a_none_zero, out_valid_o && !found_o |-> position_o == '0)

  // The input side only stalls when the result was stalled the cycle before.
  `WWPS_ASSERT(a_stall_cause, !in_ready_o |-> $past(out_valid_o && !out_ready_i))

  // The register port never pushes back.
  `WWPS_ASSERT_ALWAYS(a_cfg_ready, rst_ni |-> cfg_ready_o)

endmodule

bind whole_word_pattern_search wwps_checker u_wwps_checker (.*);
